// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the scoped symbol table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int TABLE_CW    = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [63:0] name;
		logic [7:0]  scope;
		logic [7:0]  value;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic scan_init;
		logic scan_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic early_bad;
		logic scan_done;
	} sts_t;

endpackage

// ===== rtl/sst_ram.sv =====
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: capture request, pre-check, table scan, result hand-off.
// ----------------------------------------------------------------------------
module sst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  sst_pkg::sts_t sts,
	output sst_pkg::cmd_t cmd
);

	import sst_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.early_bad ? S_RESULT : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_CHECK: begin
				cmd.scan_init = !sts.early_bad;
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			S_RESULT: begin
				cmd.commit = rsp_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/sst_dp.sv =====
// ----------------------------------------------------------------------------
// sst_dp
// Datapath: request registers, entry RAM, scan/compare stage, live count and
// result word register.
// ----------------------------------------------------------------------------
module sst_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sst_pkg::cmd_t cmd,
	output sst_pkg::sts_t sts,
	input  logic [1:0]    action,
	input  logic [63:0]   name_key,
	input  logic [7:0]    scope_level,
	input  logic [7:0]    write_value,
	input  logic [3:0]    slot,
	output logic [2:0]    status,
	output logic [3:0]    hit_slot,
	output logic [7:0]    hit_value,
	output logic [7:0]    hit_scope,
	output logic [4:0]    entry_count
);

	import sst_pkg::*;

	// request word
	action_t     req_action_q;
	logic [63:0] req_key_q;
	logic [7:0]  req_scope_q;
	logic [7:0]  req_value_q;
	logic [3:0]  req_slot_q;

	logic [TABLE_CW-1:0] live_q;
	logic [TABLE_CW-1:0] rd_idx_q;
	logic [TABLE_CW-1:0] end_q;
	logic [TABLE_CW-1:0] cmp_idx_s1;
	logic                cmp_vld_s1;

	logic                dup_q;
	logic                found_q;
	logic [TABLE_CW-1:0] best_idx_q;
	logic [7:0]          best_val_q;
	logic [7:0]          best_scope_q;

	logic [2:0] status_q;
	logic [3:0] hit_slot_q;
	logic [7:0] hit_value_q;
	logic [7:0] hit_scope_q;
	logic [4:0] entry_count_q;

	logic                early_bad;
	logic [TABLE_CW-1:0] slot_cw;
	logic [TABLE_CW-1:0] prev_idx;
	logic [TABLE_CW-1:0] live_next;
	logic                rd_go;
	entry_t              rdata;
	logic                name_hit;
	logic                wr_en;
	logic [TABLE_AW-1:0] wr_addr;
	entry_t              wr_data;
	status_t             res_status;
	logic                res_ok;

	assign slot_cw  = TABLE_CW'(req_slot_q);
	assign prev_idx = cmp_idx_s1 - 1'b1;

	always_comb begin
		early_bad = 1'b0;
		case (req_action_q)
			ACT_ADD:    early_bad = (req_key_q == 64'd0);
			ACT_LOOKUP: early_bad = 1'b0;
			default:    early_bad = (int'(req_slot_q) >= int'(live_q));
		endcase
	end

	assign rd_go = cmd.scan_en && (rd_idx_q != end_q);

	assign sts.early_bad = early_bad;
	assign sts.scan_done = (rd_idx_q == end_q) && !cmp_vld_s1;

	assign name_hit = (rdata.name == req_key_q);

	always_comb begin
		if (early_bad) begin
			res_status = ST_BAD;
		end else begin
			case (req_action_q)
				ACT_ADD: begin
					if (dup_q) res_status = ST_DUPLICATE;
					else if (int'(live_q) == TABLE_DEPTH) res_status = ST_FULL;
					else res_status = ST_OK;
				end
				ACT_LOOKUP: res_status = found_q ? ST_OK : ST_NOT_FOUND;
				default:    res_status = ST_OK;
			endcase
		end
	end

	assign res_ok = (res_status == ST_OK);

	always_comb begin
		live_next = live_q;
		if (res_ok && req_action_q == ACT_ADD) live_next = live_q + 1'b1;
		if (res_ok && req_action_q == ACT_DELETE) live_next = live_q - 1'b1;
	end

	// one RAM write port: scan-time writes (update, delete shift) or add at commit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = live_q[TABLE_AW-1:0];
		wr_data = '{name: req_key_q, scope: req_scope_q, value: req_value_q};
		if (cmp_vld_s1 && req_action_q == ACT_UPDATE) begin
			wr_en   = 1'b1;
			wr_addr = slot_cw[TABLE_AW-1:0];
			wr_data = '{name: rdata.name, scope: rdata.scope, value: req_value_q};
		end else if (cmp_vld_s1 && req_action_q == ACT_DELETE && cmp_idx_s1 != slot_cw) begin
			wr_en   = 1'b1;
			wr_addr = prev_idx[TABLE_AW-1:0];
			wr_data = rdata;
		end else if (cmd.commit && res_ok && req_action_q == ACT_ADD) begin
			wr_en = 1'b1;
		end
	end

	sst_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_go),
		.rd_addr (rd_idx_q[TABLE_AW-1:0]),
		.rd_data (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_action_q <= action_t'(action);
			req_key_q    <= name_key;
			req_scope_q  <= scope_level;
			req_value_q  <= write_value;
			req_slot_q   <= slot;
		end
		cmp_idx_s1 <= rd_idx_q;
		if (cmp_vld_s1) begin
			case (req_action_q)
				ACT_LOOKUP: begin
					if (name_hit && rdata.scope <= req_scope_q &&
					    (!found_q || rdata.scope > best_scope_q)) begin
						best_idx_q   <= cmp_idx_s1;
						best_val_q   <= rdata.value;
						best_scope_q <= rdata.scope;
					end
				end
				ACT_UPDATE: begin
					best_val_q   <= req_value_q;
					best_scope_q <= rdata.scope;
				end
				ACT_DELETE: begin
					if (cmp_idx_s1 == slot_cw) begin
						best_val_q   <= rdata.value;
						best_scope_q <= rdata.scope;
					end
				end
				default: ;
			endcase
		end
		if (cmd.commit) begin
			status_q      <= res_status;
			entry_count_q <= 5'(live_next);
			if (!res_ok) begin
				hit_slot_q  <= 4'd0;
				hit_value_q <= 8'd0;
				hit_scope_q <= 8'd0;
			end else if (req_action_q == ACT_ADD) begin
				hit_slot_q  <= 4'(live_q);
				hit_value_q <= req_value_q;
				hit_scope_q <= req_scope_q;
			end else if (req_action_q == ACT_LOOKUP) begin
				hit_slot_q  <= 4'(best_idx_q);
				hit_value_q <= best_val_q;
				hit_scope_q <= best_scope_q;
			end else begin
				hit_slot_q  <= req_slot_q;
				hit_value_q <= best_val_q;
				hit_scope_q <= best_scope_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			rd_idx_q   <= '0;
			end_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			dup_q      <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_go;
			if (rd_go) rd_idx_q <= rd_idx_q + 1'b1;
			if (cmd.scan_init) begin
				dup_q   <= 1'b0;
				found_q <= 1'b0;
				case (req_action_q)
					ACT_ADD, ACT_LOOKUP: begin
						rd_idx_q <= '0;
						end_q    <= live_q;
					end
					ACT_UPDATE: begin
						rd_idx_q <= slot_cw;
						end_q    <= slot_cw + 1'b1;
					end
					default: begin
						rd_idx_q <= slot_cw;
						end_q    <= live_q;
					end
				endcase
			end
			if (cmp_vld_s1 && name_hit) begin
				if (req_action_q == ACT_ADD && rdata.scope == req_scope_q) dup_q <= 1'b1;
				if (req_action_q == ACT_LOOKUP && rdata.scope <= req_scope_q) found_q <= 1'b1;
			end
			if (cmd.commit) live_q <= live_next;
		end
	end

	assign status      = status_q;
	assign hit_slot    = hit_slot_q;
	assign hit_value   = hit_value_q;
	assign hit_scope   = hit_scope_q;
	assign entry_count = entry_count_q;

endmodule

// ===== rtl/scoped_symbol_table_unit.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_table_unit
// Table of named 8-bit variables tagged with scope levels: add, lookup,
// update and delete, one status word per request.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries one word: action, name_key,
// scope_level, write_value, slot. Response channel (rsp_valid/rsp_ready)
// returns one word per request: status, hit_slot, hit_value, hit_scope,
// entry_count.
// Requests are handled one at a time. After acceptance there is a check
// state, then a scan that reads the entry RAM one entry per cycle (its single
// read port sets the pace), then a result state that holds until the output
// register is free. Add and lookup scan every live entry, update reads only
// its slot, and delete reads from its slot up while entries shift down as
// read. Requests rejected up front (empty name, bad slot) skip the scan.
// req_ready is high while the unit is idle, so the next request is taken
// while the previous response still waits in the output register. A stalled
// receiver holds the finished word; the next result waits until it is taken.
// Reset empties the table (live count zero); entry RAM contents are not
// cleared since only slots below the live count are ever read.
// ----------------------------------------------------------------------------
module scoped_symbol_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  action,
	input  logic [63:0] name_key,
	input  logic [7:0]  scope_level,
	input  logic [7:0]  write_value,
	input  logic [3:0]  slot,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [3:0]  hit_slot,
	output logic [7:0]  hit_value,
	output logic [7:0]  hit_scope,
	output logic [4:0]  entry_count
);

	import sst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sst_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.name_key    (name_key),
		.scope_level (scope_level),
		.write_value (write_value),
		.slot        (slot),
		.status      (status),
		.hit_slot    (hit_slot),
		.hit_value   (hit_value),
		.hit_scope   (hit_scope),
		.entry_count (entry_count)
	);

`ifndef NO_ASSERTIONS
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> hit_slot == 4'd0 && hit_value == 8'd0 &&
		hit_scope == 8'd0)
		else $error("error response with nonzero hit fields");

	a_commit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.scan_done || sts.early_bad)
		else $error("result committed before scan finished");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= ST_BAD)
		else $error("status code out of range");
`endif

endmodule
